>>> hdl/sbfr_pkg.sv
// ----------------------------------------------------------------------------
// sbfr_pkg: shared types and constants for the sprite blitter
// Field widths, geometry constants, command and register codes, microcode.
// ----------------------------------------------------------------------------
package sbfr_pkg;

    // geometry
    localparam int TILE_SIZE     = 8;
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 128;
    localparam int TILES_PER_ROW = 16;
    localparam int SHEET_STRIDE  = 128;

    // field widths
    localparam int ADDR_W  = 14;
    localparam int COLOR_W = 8;
    localparam int ID_W    = 8;
    localparam int POS_W   = 10;
    localparam int XY_W    = POS_W + 1;
    localparam int TILE_W  = $clog2(TILE_SIZE);
    localparam int SHEET_DEPTH = 1 << ADDR_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_REMAP  = 16;

    localparam logic [TILE_W-1:0] TILE_MAX = TILE_W'(TILE_SIZE - 1);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_REMAP_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REMAP_HIGH = 1'd1;

    localparam logic [CFG_DATA_W-1:0] REMAP_LOW_RST  = 64'h0706050403020100;
    localparam logic [CFG_DATA_W-1:0] REMAP_HIGH_RST = 64'h0F0E0D0C0B0A0908;

    // microcode
    typedef logic [1:0] t_step;
    localparam int    NUM_STEPS  = 4;
    localparam t_step STEP_IDLE  = 2'd0;
    localparam t_step STEP_WALK  = 2'd1;
    localparam t_step STEP_DRAIN = 2'd2;
    localparam t_step STEP_FLUSH = 2'd3;

    typedef enum logic [1:0] {
        C_ALWAYS   = 2'd0,
        C_DRAW     = 2'd1,
        C_TILE_END = 2'd2
    } t_cond;

    typedef struct packed {
        logic  in_rdy;   // take an input item
        logic  issue;    // issue a sheet read, advance pixel counter
        logic  proc_b;   // handle read data of the previous pixel
        logic  flush;    // release the held pixel as the last write
        t_cond cond;     // branch condition
        t_step target;   // branch target; else stay on this step
    } t_uword;

    localparam t_uword UCODE [NUM_STEPS] = '{
        '{in_rdy: 1'b1, issue: 1'b0, proc_b: 1'b0, flush: 1'b0,
          cond: C_DRAW,     target: STEP_WALK},
        '{in_rdy: 1'b0, issue: 1'b1, proc_b: 1'b1, flush: 1'b0,
          cond: C_TILE_END, target: STEP_DRAIN},
        '{in_rdy: 1'b0, issue: 1'b0, proc_b: 1'b1, flush: 1'b0,
          cond: C_ALWAYS,   target: STEP_FLUSH},
        '{in_rdy: 1'b0, issue: 1'b0, proc_b: 1'b0, flush: 1'b1,
          cond: C_ALWAYS,   target: STEP_IDLE}
    };

    // colours below 16 go through the remap table
    function automatic logic [COLOR_W-1:0] remap_color(
        input logic [COLOR_W-1:0]    c,
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi
    );
        logic [2*CFG_DATA_W-1:0] tbl;
        tbl = {hi, lo};
        if (c < COLOR_W'(NUM_REMAP)) begin
            return tbl[{c[3:0], 3'b000} +: COLOR_W];
        end
        return c;
    endfunction

endpackage

>>> hdl/sbfr_in_if.sv
// ----------------------------------------------------------------------------
// sbfr_in_if: command channel of the sprite blitter
// Valid/ready channel carrying one load or draw command per item.
// ----------------------------------------------------------------------------
interface sbfr_in_if;
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [sbfr_pkg::ADDR_W-1:0]     sheet_addr;
    logic [sbfr_pkg::COLOR_W-1:0]    sheet_pixel;
    logic [sbfr_pkg::ID_W-1:0]       sprite_id;
    logic signed [sbfr_pkg::POS_W-1:0] pos_x;
    logic signed [sbfr_pkg::POS_W-1:0] pos_y;
    logic                            mirror_x;
    logic                            mirror_y;

    modport source (
        output valid, command, sheet_addr, sheet_pixel, sprite_id,
               pos_x, pos_y, mirror_x, mirror_y,
        input  ready
    );
    modport sink (
        input  valid, command, sheet_addr, sheet_pixel, sprite_id,
               pos_x, pos_y, mirror_x, mirror_y,
        output ready
    );
endinterface

>>> hdl/sbfr_out_if.sv
// ----------------------------------------------------------------------------
// sbfr_out_if: framebuffer write channel of the sprite blitter
// Valid/ready channel carrying one framebuffer write per item.
// ----------------------------------------------------------------------------
interface sbfr_out_if;
    logic                         valid;
    logic                         ready;
    logic [sbfr_pkg::ADDR_W-1:0]  fb_addr;
    logic [sbfr_pkg::COLOR_W-1:0] pixel_color;
    logic                         last_write;

    modport source (
        output valid, fb_addr, pixel_color, last_write,
        input  ready
    );
    modport sink (
        input  valid, fb_addr, pixel_color, last_write,
        output ready
    );
endinterface

>>> hdl/sbfr_ram.sv
// ----------------------------------------------------------------------------
// sbfr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module sbfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sprite_blitter_flip_remap_unit.sv
// ----------------------------------------------------------------------------
// sprite_blitter_flip_remap_unit: sprite blitter with mirroring and remap
// Loads a 128x128 byte sprite sheet and draws 8x8 tiles as framebuffer writes.
// ----------------------------------------------------------------------------
// A load item writes one byte of the 16K sprite sheet and gives no output.
// A draw item walks the 8x8 tile in screen order, one pixel per cycle while
// the output side does not stall, through a single sheet read port: a draw
// passes the accept step, the walk over all 64 pixels, a read-drain step and
// a final flush step, with the input not ready after the accept step.
// Off-screen pixels are clipped, colour 0 is skipped, colours 1..15 go
// through the 16-entry remap held in remap_low / remap_high, and each drawn
// pixel leaves as one framebuffer write. One pixel is always held back so
// the final write of a draw can carry last_write; a draw with nothing
// visible gives no output. The sheet has no reset: reading a byte that was
// never loaded gives an undefined colour. Remap registers are written through
// the plain config port (index 0 = low, 1 = high); the user must write them
// only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module sprite_blitter_flip_remap_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sbfr_in_if.sink                           i_in,
    sbfr_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [sbfr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sbfr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [sbfr_pkg::CFG_DATA_W-1:0] r_remap_low;
    logic [sbfr_pkg::CFG_DATA_W-1:0] r_remap_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remap_low  <= sbfr_pkg::REMAP_LOW_RST;
            r_remap_high <= sbfr_pkg::REMAP_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbfr_pkg::CFG_REMAP_LOW:  r_remap_low  <= i_cfg_data;
                sbfr_pkg::CFG_REMAP_HIGH: r_remap_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: step counter indexes the microcode ROM
    // ------------------------------------------------------------------
    sbfr_pkg::t_step  r_step, n_step;
    sbfr_pkg::t_uword uw;

    // draw context
    logic signed [sbfr_pkg::POS_W-1:0]  r_pos_x, r_pos_y;
    logic                               r_mx, r_my;
    logic [sbfr_pkg::ADDR_W-1:0]        r_tile_base;
    logic [sbfr_pkg::TILE_W-1:0]        r_px, r_py;

    // read stage: pixel whose sheet read is in flight
    logic                               r_b_vld;
    logic [sbfr_pkg::ADDR_W-1:0]        r_b_fb;

    // held pixel, released once the next visible one shows up or at flush
    logic                               r_pend_vld;
    logic [sbfr_pkg::ADDR_W-1:0]        r_pend_fb;
    logic [sbfr_pkg::COLOR_W-1:0]       r_pend_color;

    // output register
    logic                               r_out_vld;
    logic [sbfr_pkg::ADDR_W-1:0]        r_out_fb;
    logic [sbfr_pkg::COLOR_W-1:0]       r_out_color;
    logic                               r_out_last;

    logic                               in_fire, draw_fire, load_fire;
    logic                               tile_end, cond_true;
    logic                               b_opaque, need_out, out_free, go;
    logic                               out_take, b_move, f_move;

    logic signed [sbfr_pkg::XY_W-1:0]   dx, dy;
    logic                               vis;
    logic [sbfr_pkg::TILE_W-1:0]        sx, sy;
    logic [sbfr_pkg::ADDR_W-1:0]        rd_addr, fb_addr, tile_base;
    logic                               ram_re;
    logic [sbfr_pkg::COLOR_W-1:0]       ram_rdata;

    assign uw = sbfr_pkg::UCODE[r_step];

    assign i_in.ready = uw.in_rdy;
    assign in_fire    = i_in.valid && uw.in_rdy;
    assign draw_fire  = in_fire && (i_in.command == sbfr_pkg::CMD_DRAW);
    assign load_fire  = in_fire && (i_in.command == sbfr_pkg::CMD_LOAD);

    assign tile_end = (r_px == sbfr_pkg::TILE_MAX) && (r_py == sbfr_pkg::TILE_MAX);

    always_comb begin
        case (uw.cond)
            sbfr_pkg::C_ALWAYS:   cond_true = 1'b1;
            sbfr_pkg::C_DRAW:     cond_true = draw_fire;
            sbfr_pkg::C_TILE_END: cond_true = tile_end;
            default:              cond_true = 1'b0;
        endcase
    end

    // Stall only when a pixel has to move into a busy output register.
    assign b_opaque = r_b_vld && (ram_rdata != '0);
    assign need_out = (uw.proc_b && b_opaque && r_pend_vld) || (uw.flush && r_pend_vld);
    assign out_take = r_out_vld && o_out.ready;
    assign out_free = !r_out_vld || o_out.ready;
    assign go       = !need_out || out_free;

    assign n_step = (go && cond_true) ? uw.target : r_step;

    // ------------------------------------------------------------------
    // Address datapath
    // ------------------------------------------------------------------
    assign tile_base =
        sbfr_pkg::ADDR_W'(i_in.sprite_id / sbfr_pkg::TILES_PER_ROW)
            * sbfr_pkg::ADDR_W'(sbfr_pkg::TILE_SIZE * sbfr_pkg::SHEET_STRIDE)
        + sbfr_pkg::ADDR_W'(i_in.sprite_id % sbfr_pkg::TILES_PER_ROW)
            * sbfr_pkg::ADDR_W'(sbfr_pkg::TILE_SIZE);

    assign dx = sbfr_pkg::XY_W'(r_pos_x) + sbfr_pkg::XY_W'($signed({1'b0, r_px}));
    assign dy = sbfr_pkg::XY_W'(r_pos_y) + sbfr_pkg::XY_W'($signed({1'b0, r_py}));

    // clip: non-negative and below the screen size
    assign vis = !dx[sbfr_pkg::XY_W-1]
              && (dx[sbfr_pkg::XY_W-2:0] < (sbfr_pkg::XY_W-1)'(sbfr_pkg::SCREEN_WIDTH))
              && !dy[sbfr_pkg::XY_W-1]
              && (dy[sbfr_pkg::XY_W-2:0] < (sbfr_pkg::XY_W-1)'(sbfr_pkg::SCREEN_HEIGHT));

    assign sx = r_mx ? (sbfr_pkg::TILE_MAX - r_px) : r_px;
    assign sy = r_my ? (sbfr_pkg::TILE_MAX - r_py) : r_py;

    assign rd_addr = r_tile_base
                   + sbfr_pkg::ADDR_W'(sy) * sbfr_pkg::ADDR_W'(sbfr_pkg::SHEET_STRIDE)
                   + sbfr_pkg::ADDR_W'(sx);

    assign fb_addr = sbfr_pkg::ADDR_W'(dy[sbfr_pkg::XY_W-2:0])
                       * sbfr_pkg::ADDR_W'(sbfr_pkg::SCREEN_WIDTH)
                   + sbfr_pkg::ADDR_W'(dx[sbfr_pkg::XY_W-2:0]);

    assign ram_re = uw.issue && go && vis;

    sbfr_ram #(
        .WIDTH (sbfr_pkg::COLOR_W),
        .DEPTH (sbfr_pkg::SHEET_DEPTH)
    ) u_sheet (
        .i_clk   (i_clk),
        .i_we    (load_fire),
        .i_waddr (i_in.sheet_addr),
        .i_wdata (i_in.sheet_pixel),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign b_move = uw.proc_b && go && b_opaque;
    assign f_move = uw.flush && go && r_pend_vld;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= sbfr_pkg::STEP_IDLE;
            r_px       <= '0;
            r_py       <= '0;
            r_b_vld    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_step <= n_step;

            if (draw_fire) begin
                r_px <= '0;
                r_py <= '0;
            end else if (uw.issue && go) begin
                if (r_px == sbfr_pkg::TILE_MAX) begin
                    r_px <= '0;
                    r_py <= r_py + 1'b1;
                end else begin
                    r_px <= r_px + 1'b1;
                end
            end

            if (uw.issue && go) begin
                r_b_vld <= vis;
            end else if (uw.proc_b && go) begin
                r_b_vld <= 1'b0;
            end

            if (b_move) begin
                r_pend_vld <= 1'b1;
            end else if (f_move) begin
                r_pend_vld <= 1'b0;
            end

            if ((b_move && r_pend_vld) || f_move) begin
                r_out_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (draw_fire) begin
            r_pos_x     <= i_in.pos_x;
            r_pos_y     <= i_in.pos_y;
            r_mx        <= i_in.mirror_x;
            r_my        <= i_in.mirror_y;
            r_tile_base <= tile_base;
        end
        if (uw.issue && go) begin
            r_b_fb <= fb_addr;
        end
        if (b_move) begin
            r_pend_fb    <= r_b_fb;
            r_pend_color <= sbfr_pkg::remap_color(ram_rdata, r_remap_low, r_remap_high);
        end
        if (b_move && r_pend_vld) begin
            r_out_fb    <= r_pend_fb;
            r_out_color <= r_pend_color;
            r_out_last  <= 1'b0;
        end else if (f_move) begin
            r_out_fb    <= r_pend_fb;
            r_out_color <= r_pend_color;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.fb_addr     = r_out_fb;
    assign o_out.pixel_color = r_out_color;
    assign o_out.last_write  = r_out_last;

`ifndef SYNTHESIS
    // Between draws nothing is held back or in flight.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == sbfr_pkg::STEP_IDLE) |-> (!r_pend_vld && !r_b_vld))
        else $error("pixel left over after draw");

    // The read stage is drained before the flush step.
    a_flush_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == sbfr_pkg::STEP_FLUSH) |-> !r_b_vld)
        else $error("read stage busy at flush");

    // A flushed pixel appears as the flagged final write.
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_move |=> (r_out_vld && r_out_last))
        else $error("flush did not produce last write");
`endif

endmodule

>>> verif/sprite_blitter_flip_remap_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite_blitter_flip_remap_unit_tb: self-checking bench for the sprite blitter
// Fills tiles of the sprite sheet, draws them mirrored, clipped and remapped
// under several palettes, and checks every framebuffer write in order.
// ----------------------------------------------------------------------------
module sprite_blitter_flip_remap_unit_tb;

    // One command item as the driver puts it on the wire
    typedef struct {
        logic                               command;
        logic [sbfr_pkg::ADDR_W-1:0]        sheet_addr;
        logic [sbfr_pkg::COLOR_W-1:0]       sheet_pixel;
        logic [sbfr_pkg::ID_W-1:0]          sprite_id;
        logic signed [sbfr_pkg::POS_W-1:0]  pos_x;
        logic signed [sbfr_pkg::POS_W-1:0]  pos_y;
        logic                               mirror_x;
        logic                               mirror_y;
    } t_blit_cmd;

    // One framebuffer write item
    typedef struct {
        logic [sbfr_pkg::ADDR_W-1:0]  fb_addr;
        logic [sbfr_pkg::COLOR_W-1:0] pixel_color;
        logic                         last_write;
    } t_fb_write;

    // How a tile gets its contents when it is loaded
    typedef enum int {
        FILL_RAMP,     // 0..63 in sheet order: transparent corner, remapped and raw
        FILL_DESCEND,  // 255 down to 193, last pixel transparent
        FILL_BLANK,    // all transparent
        FILL_MIXED,    // random mix of transparent, remapped and raw colours
        FILL_SPARSE    // mostly transparent
    } t_fill_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                            cfg_we   = 1'b0;
    logic [sbfr_pkg::CFG_IDX_W-1:0]  cfg_idx  = sbfr_pkg::CFG_REMAP_LOW;
    logic [sbfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    sbfr_in_if  cmd_if ();
    sbfr_out_if fb_if ();

    sprite_blitter_flip_remap_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_if),
        .o_out      (fb_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------------
    // Bench-side copy of the block state
    // ------------------------------------------------------------------------
    logic [sbfr_pkg::COLOR_W-1:0] sheet_copy [sbfr_pkg::SHEET_DEPTH];
    logic [sbfr_pkg::COLOR_W-1:0] palette [sbfr_pkg::NUM_REMAP];

    t_blit_cmd cmd_backlog[$];        // items waiting to be driven
    t_fb_write pending_fb_writes[$];  // framebuffer writes still owed by the block

    int  gap_pct    = 21;   // idle percentage on both sides
    int  bad_writes = 0;
    logic cmd_taken = 1'b0;

    // Only fully loaded tiles are ever drawn: an unwritten sheet byte is never read
    bit  tile_loaded [256];
    int  drawable[$];

    // A remap register holds eight palette entries, low entry in the low byte
    function automatic void load_palette(input logic [sbfr_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [sbfr_pkg::CFG_DATA_W-1:0] data);
        int base;
        base = (idx == sbfr_pkg::CFG_REMAP_HIGH) ? 8 : 0;
        for (int i = 0; i < 8; i++) begin
            palette[base + i] = data[8*i +: 8];
        end
    endfunction

    function automatic logic [sbfr_pkg::COLOR_W-1:0] remapped(
        input logic [sbfr_pkg::COLOR_W-1:0] c
    );
        if (c < sbfr_pkg::NUM_REMAP) begin
            return palette[c[3:0]];
        end
        return c;
    endfunction

    // Walk the tile in screen order, row by row, and queue every visible,
    // non-transparent pixel. One write is held back so the final one of the
    // draw can be tagged with last_write.
    function automatic void blit_tile(input t_blit_cmd cmd);
        int                           tile_x, tile_y, scr_x, scr_y, src_x, src_y;
        logic [sbfr_pkg::ADDR_W-1:0]  idx;
        logic [sbfr_pkg::COLOR_W-1:0] colr;
        t_fb_write                    held;
        bit                           have_held;
        have_held = 1'b0;
        tile_x = int'(cmd.sprite_id % sbfr_pkg::TILES_PER_ROW) * sbfr_pkg::TILE_SIZE;
        tile_y = int'(cmd.sprite_id / sbfr_pkg::TILES_PER_ROW) * sbfr_pkg::TILE_SIZE;
        for (int py = 0; py < sbfr_pkg::TILE_SIZE; py++) begin
            scr_y = int'(cmd.pos_y) + py;
            if (scr_y < 0 || scr_y >= sbfr_pkg::SCREEN_HEIGHT) continue;
            src_y = cmd.mirror_y ? (sbfr_pkg::TILE_SIZE - 1 - py) : py;
            for (int px = 0; px < sbfr_pkg::TILE_SIZE; px++) begin
                scr_x = int'(cmd.pos_x) + px;
                if (scr_x < 0 || scr_x >= sbfr_pkg::SCREEN_WIDTH) continue;
                src_x = cmd.mirror_x ? (sbfr_pkg::TILE_SIZE - 1 - px) : px;
                idx  = sbfr_pkg::ADDR_W'((tile_y + src_y) * sbfr_pkg::SHEET_STRIDE
                                         + tile_x + src_x);
                colr = sheet_copy[idx];
                if (colr == '0) continue;   // transparent
                if (have_held) pending_fb_writes.push_back(held);
                held.fb_addr     = sbfr_pkg::ADDR_W'(scr_y * sbfr_pkg::SCREEN_WIDTH + scr_x);
                held.pixel_color = remapped(colr);
                held.last_write  = 1'b0;
                have_held        = 1'b1;
            end
        end
        if (have_held) begin
            held.last_write = 1'b1;
            pending_fb_writes.push_back(held);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Item builders; fields the command ignores still get random values
    // ------------------------------------------------------------------------
    function automatic t_blit_cmd load_item(input int addr, input int pix);
        t_blit_cmd r;
        r.command     = sbfr_pkg::CMD_LOAD;
        r.sheet_addr  = sbfr_pkg::ADDR_W'(addr);
        r.sheet_pixel = sbfr_pkg::COLOR_W'(pix);
        r.sprite_id   = sbfr_pkg::ID_W'($urandom);
        r.pos_x       = sbfr_pkg::POS_W'($urandom);
        r.pos_y       = sbfr_pkg::POS_W'($urandom);
        r.mirror_x    = 1'($urandom);
        r.mirror_y    = 1'($urandom);
        return r;
    endfunction

    function automatic void push_draw(input int id, input int x, input int y,
                                      input bit mx, input bit my);
        t_blit_cmd r;
        r.command     = sbfr_pkg::CMD_DRAW;
        r.sheet_addr  = sbfr_pkg::ADDR_W'($urandom);
        r.sheet_pixel = sbfr_pkg::COLOR_W'($urandom);
        r.sprite_id   = sbfr_pkg::ID_W'(id);
        r.pos_x       = sbfr_pkg::POS_W'(x);
        r.pos_y       = sbfr_pkg::POS_W'(y);
        r.mirror_x    = mx;
        r.mirror_y    = my;
        cmd_backlog.push_back(r);
    endfunction

    function automatic int fill_pixel(input t_fill_mode mode, input int r, input int c);
        int roll;
        roll = $urandom_range(99);
        case (mode)
            FILL_RAMP:    return r * 8 + c;
            FILL_DESCEND: return (r == 7 && c == 7) ? 0 : 255 - (r * 8 + c);
            FILL_BLANK:   return 0;
            FILL_MIXED: begin
                if (roll < 25) return 0;
                if (roll < 60) return $urandom_range(15, 1);
                return $urandom_range(255, 16);
            end
            default:      return (roll < 85) ? 0 : $urandom_range(255, 1);
        endcase
    endfunction

    // Fill all 64 bytes of a tile in shuffled order, then mark it drawable
    function automatic void load_tile(input int id, input t_fill_mode mode);
        int order [sbfr_pkg::TILE_SIZE*sbfr_pkg::TILE_SIZE];
        int j, tmp, r, c;
        for (int i = 0; i < sbfr_pkg::TILE_SIZE*sbfr_pkg::TILE_SIZE; i++) order[i] = i;
        for (int i = sbfr_pkg::TILE_SIZE*sbfr_pkg::TILE_SIZE - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < sbfr_pkg::TILE_SIZE*sbfr_pkg::TILE_SIZE; k++) begin
            r = order[k] / sbfr_pkg::TILE_SIZE;
            c = order[k] % sbfr_pkg::TILE_SIZE;
            cmd_backlog.push_back(load_item(
                ((id / sbfr_pkg::TILES_PER_ROW) * sbfr_pkg::TILE_SIZE + r)
                    * sbfr_pkg::SHEET_STRIDE
                + (id % sbfr_pkg::TILES_PER_ROW) * sbfr_pkg::TILE_SIZE + c,
                fill_pixel(mode, r, c)));
        end
        if (!tile_loaded[id]) drawable.push_back(id);
        tile_loaded[id] = 1'b1;
    endfunction

    // Mostly near the screen so clipping edges get hit; now and then anywhere
    function automatic int rand_pos();
        if ($urandom_range(99) < 80) return $urandom_range(140) - 10;
        return $urandom_range(1023) - 512;
    endfunction

    // ------------------------------------------------------------------------
    // Config writes: the block must be idle, so they only follow settle()
    // ------------------------------------------------------------------------
    task automatic write_remap(input logic [sbfr_pkg::CFG_IDX_W-1:0] idx,
                               input logic [sbfr_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        load_palette(idx, data);
    endtask

    // Wait for every item to be taken and every write to arrive, then give a
    // draw with no visible pixel time to finish its walk.
    task automatic settle();
        while (cmd_backlog.size() != 0 || cmd_if.valid || pending_fb_writes.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: new item at the falling edge once the previous one was taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cmd_taken <= i_rst_n && cmd_if.valid && cmd_if.ready;
    end

    always @(negedge i_clk) begin : drive_cmd
        t_blit_cmd nxt_cmd;
        if (i_rst_n && (!cmd_if.valid || cmd_taken)) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
                nxt_cmd = cmd_backlog.pop_front();
                cmd_if.command     <= nxt_cmd.command;
                cmd_if.sheet_addr  <= nxt_cmd.sheet_addr;
                cmd_if.sheet_pixel <= nxt_cmd.sheet_pixel;
                cmd_if.sprite_id   <= nxt_cmd.sprite_id;
                cmd_if.pos_x       <= nxt_cmd.pos_x;
                cmd_if.pos_y       <= nxt_cmd.pos_y;
                cmd_if.mirror_x    <= nxt_cmd.mirror_x;
                cmd_if.mirror_y    <= nxt_cmd.mirror_y;
                cmd_if.valid       <= 1'b1;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Framebuffer side back-pressure
    always @(negedge i_clk) begin
        fb_if.ready <= i_rst_n && ($urandom_range(99) >= gap_pct);
    end

    // ------------------------------------------------------------------------
    // Input monitor: every accepted item updates the sheet copy or is predicted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_cmd
        t_blit_cmd seen;
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            seen.command     = cmd_if.command;
            seen.sheet_addr  = cmd_if.sheet_addr;
            seen.sheet_pixel = cmd_if.sheet_pixel;
            seen.sprite_id   = cmd_if.sprite_id;
            seen.pos_x       = cmd_if.pos_x;
            seen.pos_y       = cmd_if.pos_y;
            seen.mirror_x    = cmd_if.mirror_x;
            seen.mirror_y    = cmd_if.mirror_y;
            if (seen.command == sbfr_pkg::CMD_LOAD) begin
                sheet_copy[seen.sheet_addr] = seen.sheet_pixel;
            end else begin
                blit_tile(seen);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: each framebuffer write against the oldest one owed
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_fb
        t_fb_write want;
        if (i_rst_n && fb_if.valid && fb_if.ready) begin
            if (pending_fb_writes.size() == 0) begin
                $error("unexpected framebuffer write: fb_addr %0d pixel_color %0d",
                       fb_if.fb_addr, fb_if.pixel_color);
                bad_writes++;
            end else begin
                want = pending_fb_writes.pop_front();
                if (fb_if.fb_addr !== want.fb_addr) begin
                    $error("fb_addr: expected %0d, got %0d", want.fb_addr, fb_if.fb_addr);
                    bad_writes++;
                end
                if (fb_if.pixel_color !== want.pixel_color) begin
                    $error("pixel_color: expected %0d, got %0d",
                           want.pixel_color, fb_if.pixel_color);
                    bad_writes++;
                end
                if (fb_if.last_write !== want.last_write) begin
                    $error("last_write: expected %0d, got %0d",
                           want.last_write, fb_if.last_write);
                    bad_writes++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int tid;
        cmd_if.valid       = 1'b0;
        cmd_if.command     = sbfr_pkg::CMD_LOAD;
        cmd_if.sheet_addr  = '0;
        cmd_if.sheet_pixel = '0;
        cmd_if.sprite_id   = '0;
        cmd_if.pos_x       = '0;
        cmd_if.pos_y       = '0;
        cmd_if.mirror_x    = 1'b0;
        cmd_if.mirror_y    = 1'b0;
        fb_if.ready        = 1'b0;
        load_palette(sbfr_pkg::CFG_REMAP_LOW, sbfr_pkg::REMAP_LOW_RST);
        load_palette(sbfr_pkg::CFG_REMAP_HIGH, sbfr_pkg::REMAP_HIGH_RST);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sheet setup: first and last tile cover both extremes of the sheet
        // address; a blank tile gives the all-transparent draw.
        load_tile(0, FILL_RAMP);
        load_tile(255, FILL_DESCEND);
        load_tile(8'h5A, FILL_BLANK);

        // Directed draws under the identity palette
        push_draw(0, 0, 0, 1'b0, 1'b0);          // each mirror combination
        push_draw(0, 0, 0, 1'b1, 1'b0);
        push_draw(0, 0, 0, 1'b0, 1'b1);
        push_draw(0, 0, 0, 1'b1, 1'b1);
        push_draw(255, 120, 120, 1'b0, 1'b0);    // bottom-right corner, corner pixel transparent
        push_draw(255, -4, -4, 1'b1, 1'b1);      // clipped on top and left
        push_draw(255, 124, 60, 1'b0, 1'b1);     // clipped on the right
        push_draw(0, 60, 124, 1'b1, 1'b0);       // clipped at the bottom
        push_draw(0, -8, 0, 1'b0, 1'b0);         // fully off screen, each side
        push_draw(0, 128, 0, 1'b0, 1'b0);
        push_draw(0, 0, -8, 1'b0, 1'b0);
        push_draw(255, 0, 128, 1'b1, 1'b1);
        push_draw(0, -512, -512, 1'b1, 1'b1);    // position extremes
        push_draw(255, 511, 511, 1'b0, 1'b0);
        push_draw(8'h5A, 40, 40, 1'b0, 1'b0);    // transparent tile
        push_draw(0, -7, -7, 1'b0, 1'b0);        // single visible pixel
        push_draw(255, 127, 127, 1'b0, 1'b0);
        push_draw(0, -1, 121, 1'b1, 1'b0);
        push_draw(255, 56, 0, 1'b1, 1'b1);
        cmd_backlog.push_back(load_item(130, 8'h80));  // overwrite inside tile 0
        push_draw(0, 10, 10, 1'b0, 1'b0);
        settle();

        // Random rounds, each with its own palette; the second round runs
        // with no idling on either side.
        for (int rnd = 0; rnd < 4; rnd++) begin
            case (rnd)
                0, 3: begin
                    write_remap(sbfr_pkg::CFG_REMAP_LOW, {$urandom, $urandom});
                    write_remap(sbfr_pkg::CFG_REMAP_HIGH, {$urandom, $urandom});
                end
                1: begin
                    write_remap(sbfr_pkg::CFG_REMAP_LOW, '0);
                    write_remap(sbfr_pkg::CFG_REMAP_HIGH, '1);
                end
                default: begin
                    write_remap(sbfr_pkg::CFG_REMAP_LOW, '1);
                    write_remap(sbfr_pkg::CFG_REMAP_HIGH, '0);
                end
            endcase
            gap_pct = (rnd == 1) ? 0 : 21;

            if (rnd % 2 == 0) begin
                do tid = $urandom_range(255); while (tile_loaded[tid]);
                load_tile(tid, ($urandom_range(1) != 0) ? FILL_MIXED : FILL_SPARSE);
            end

            // Draws of loaded tiles, with stray loads anywhere in the sheet
            for (int k = 0; k < 28; k++) begin
                if ($urandom_range(99) < 15) begin
                    cmd_backlog.push_back(load_item($urandom_range(sbfr_pkg::SHEET_DEPTH - 1),
                                                    $urandom_range(255)));
                end else begin
                    push_draw(drawable[$urandom_range(drawable.size() - 1)],
                              rand_pos(), rand_pos(), 1'($urandom), 1'($urandom));
                end
            end
            settle();
        end

        if (bad_writes == 0 && pending_fb_writes.size() == 0) begin
            $display("sprite_blitter_flip_remap_unit: match");
        end else begin
            $display("sprite_blitter_flip_remap_unit: mismatch");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #1000000;
        $display("sprite_blitter_flip_remap_unit: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
hdl/sbfr_pkg.sv
hdl/sbfr_in_if.sv
hdl/sbfr_out_if.sv
hdl/sbfr_ram.sv
hdl/sprite_blitter_flip_remap_unit.sv
verif/sprite_blitter_flip_remap_unit_tb.sv
